// ----- design/app_pkg.sv -----
// shared types, constants and table address helpers for the automaton path probability block
`timescale 1ns / 1ps

package app_pkg;

  // automaton size and number format
  localparam int NUM_STATES     = 64;
  localparam int ALPHA_SIZE     = 4;
  localparam int PROB_FRAC_BITS = 16;

  // field widths
  localparam int STATE_W     = 6;
  localparam int SYM_W       = 2;
  localparam int ACT_W       = 2;
  localparam int PROB_W      = PROB_FRAC_BITS + 1;
  localparam int TABLE_DEPTH = NUM_STATES * ALPHA_SIZE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [PROB_W-1:0] ONE_PROB = PROB_W'(1) << PROB_FRAC_BITS;

  // request kinds
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SYM   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EMPTY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TRANS = 2'd3;

  // result kinds
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_TRANS = 1'b1;

  // one table entry: transition valid, next state, emission probability
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] next;
    logic [PROB_W-1:0]  prob;
  } tbl_entry_t;

  // table memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    tbl_entry_t        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // result handed to the output register
  typedef struct packed {
    logic              valid;
    logic [PROB_W-1:0] prob;
    logic              kind;
  } res_t;

  // true when (state, symbol) names a table entry
  function automatic logic slot_ok(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym);
    return (32'(st) < NUM_STATES) && (32'(sym) < ALPHA_SIZE);
  endfunction

  // flat table address of (state, symbol)
  function automatic logic [ADDR_W-1:0] slot_addr(logic [STATE_W-1:0] st,
                                                  logic [SYM_W-1:0] sym);
    return ADDR_W'(ADDR_W'(st) * ADDR_W'(ALPHA_SIZE) + ADDR_W'(sym));
  endfunction

endpackage

// ----- design/app_table_mem.sv -----
// transition and emission table: one write port, one registered read port
`timescale 1ns / 1ps

module app_table_mem
  import app_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output tbl_entry_t rdata
);

  tbl_entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ----- design/app_ctrl.sv -----
// sequencer: table writes, empty-word answers, word walk with running product, transition sums
`timescale 1ns / 1ps

module app_ctrl
  import app_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input request
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   action,
  input  logic [STATE_W-1:0] state_index,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [STATE_W-1:0] next_state,
  input  logic               next_valid,
  input  logic [PROB_W-1:0]  entry_prob,
  input  logic               first,
  input  logic               last,
  input  logic [STATE_W-1:0] target_state,
  // table memory
  output mem_req_t           mem_req,
  input  tbl_entry_t         rdata,
  // result
  output res_t               res,
  input  logic               out_free
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SYM_RD = 3'd1;
  localparam logic [2:0] ST_WEND   = 3'd2;
  localparam logic [2:0] ST_TRANS  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHA_SIZE - 1);

  logic [2:0]         state_r,   state_nxt;
  logic [STATE_W-1:0] cur_r,     cur_nxt;
  logic               alive_r,   alive_nxt;
  logic [PROB_W-1:0]  run_r,     run_nxt;
  logic [PROB_W-1:0]  sum_r,     sum_nxt;
  logic [SYM_W-1:0]   cnt_r,     cnt_nxt;
  logic [STATE_W-1:0] st_r,      st_nxt;
  logic [STATE_W-1:0] tgt_r,     tgt_nxt;
  logic               last_r,    last_nxt;
  logic               ok_r,      ok_nxt;
  logic [PROB_W-1:0]  resp_r,    resp_nxt;
  logic               resk_r,    resk_nxt;

  logic               accept;
  logic [STATE_W-1:0] cur_use;
  logic [2*PROB_W-1:0] prod;
  logic               hit;
  logic [PROB_W:0]    sum_add;
  logic [PROB_W-1:0]  sum_new;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // start state of the lookup for a word symbol
  assign cur_use = first ? state_index : cur_r;

  // running product, truncated back to the probability format
  assign prod = (2*PROB_W)'(run_r) * (2*PROB_W)'(rdata.prob);

  // transition sum step with saturation at one
  assign hit     = rdata.valid && (rdata.next == tgt_r);
  assign sum_add = {1'b0, sum_r} + {1'b0, rdata.prob};
  assign sum_new = !hit ? sum_r :
                   (sum_add > {1'b0, ONE_PROB}) ? ONE_PROB : sum_add[PROB_W-1:0];

  assign res.valid = (state_r == ST_EMIT);
  assign res.prob  = resp_r;
  assign res.kind  = resk_r;

  // next state and memory access
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    alive_nxt = alive_r;
    run_nxt   = run_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    tgt_nxt   = tgt_r;
    last_nxt  = last_r;
    ok_nxt    = ok_r;
    resp_nxt  = resp_r;
    resk_nxt  = resk_r;

    mem_req.we          = 1'b0;
    mem_req.waddr       = slot_addr(state_index, symbol);
    mem_req.wdata.valid = next_valid;
    mem_req.wdata.next  = next_state;
    mem_req.wdata.prob  = (entry_prob > ONE_PROB) ? ONE_PROB : entry_prob;
    mem_req.raddr       = slot_addr(st_r, cnt_r + SYM_W'(1));

    case (state_r)
      ST_IDLE: begin
        mem_req.raddr = (action == ACT_SYM) ? slot_addr(cur_use, symbol)
                                            : slot_addr(state_index, '0);
        if (accept) begin
          case (action)
            ACT_WRITE: begin
              mem_req.we = slot_ok(state_index, symbol);
            end
            ACT_SYM: begin
              if (first) begin
                run_nxt   = ONE_PROB;
                alive_nxt = 1'b1;
              end
              cur_nxt   = cur_use;
              ok_nxt    = slot_ok(cur_use, symbol);
              tgt_nxt   = target_state;
              last_nxt  = last;
              state_nxt = ST_SYM_RD;
            end
            ACT_EMPTY: begin
              resp_nxt  = (state_index == target_state) ? ONE_PROB : '0;
              resk_nxt  = KIND_WORD;
              state_nxt = ST_EMIT;
            end
            default: begin
              st_nxt   = state_index;
              tgt_nxt  = target_state;
              cnt_nxt  = '0;
              sum_nxt  = '0;
              resk_nxt = KIND_TRANS;
              if (slot_ok(state_index, '0)) begin
                state_nxt = ST_TRANS;
              end else begin
                resp_nxt  = '0;
                state_nxt = ST_EMIT;
              end
            end
          endcase
        end
      end

      // entry read back: multiply in or kill the word
      ST_SYM_RD: begin
        if (alive_r) begin
          if (!ok_r || !rdata.valid) begin
            alive_nxt = 1'b0;
            run_nxt   = '0;
          end else begin
            run_nxt = prod[PROB_FRAC_BITS +: PROB_W];
            cur_nxt = rdata.next;
          end
        end
        state_nxt = last_r ? ST_WEND : ST_IDLE;
      end

      // word answer from the settled product
      ST_WEND: begin
        resp_nxt  = (alive_r && (cur_r == tgt_r)) ? run_r : '0;
        resk_nxt  = KIND_WORD;
        alive_nxt = 1'b0;
        state_nxt = ST_EMIT;
      end

      // one symbol column per cycle
      ST_TRANS: begin
        sum_nxt = sum_new;
        if (cnt_r == LAST_SYM) begin
          resp_nxt  = sum_new;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + SYM_W'(1);
        end
      end

      // hand off to the output register
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      alive_r <= 1'b0;
      run_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      alive_r <= alive_nxt;
      run_r   <= run_nxt;
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    st_r   <= st_nxt;
    tgt_r  <= tgt_nxt;
    last_r <= last_nxt;
    ok_r   <= ok_nxt;
    resp_r <= resp_nxt;
    resk_r <= resk_nxt;
  end

endmodule

// ----- design/automaton_path_probability_top.sv -----
// Sequence: a table write is done in the cycle it is accepted; a word symbol is a table read,
// then the multiply in ST_SYM_RD. Results pass ST_EMIT and the output register to out_tvalid,
// via ST_WEND for a last symbol, via ST_TRANS (one column per cycle) for a transition sum.
// Throughput: one request at a time; after a table write the port stays ready, else the next
// request waits for ST_IDLE, later while a held output blocks the hand-off.
// Reset clears the sequencer, the word registers and the output valid; the table memory is
// not cleared and holds nothing defined until written.
`timescale 1ns / 1ps

module automaton_path_probability_top
  import app_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // state_index[5:0], symbol[7:6], next_state[13:8], next_valid[14],
  // entry_prob[31:15], first[32], target_state[38:33], zero[39]
  input  logic [39:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // probability[16:0], zero[23:17]
  output logic [23:0] out_tdata,
  // result_kind[0]
  output logic        out_tuser
);

  mem_req_t   mem_req;
  tbl_entry_t rdata;
  res_t       res;
  logic       out_free;

  logic              out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0] out_prob_r,  out_prob_nxt;
  logic              out_kind_r,  out_kind_nxt;

  app_table_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  app_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .action       (in_tuser),
    .state_index  (in_tdata[5:0]),
    .symbol       (in_tdata[7:6]),
    .next_state   (in_tdata[13:8]),
    .next_valid   (in_tdata[14]),
    .entry_prob   (in_tdata[31:15]),
    .first        (in_tdata[32]),
    .last         (in_tlast),
    .target_state (in_tdata[38:33]),
    .mem_req      (mem_req),
    .rdata        (rdata),
    .res          (res),
    .out_free     (out_free)
  );

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_prob_nxt  = out_prob_r;
    out_kind_nxt  = out_kind_r;
    if (res.valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_prob_nxt  = res.prob;
      out_kind_nxt  = res.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_prob_r <= out_prob_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 24'(out_prob_r);
  assign out_tuser  = out_kind_r;

  // a table write finishes in its own cycle
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_WRITE) |=> in_tready)
    else $error("request port not ready after a table write");

  // an empty-word query has its answer ready on the next cycle
  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_EMPTY) |=> res.valid && (res.kind == KIND_WORD))
    else $error("empty-word query gave no word result");

  // no probability ever exceeds one
  a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PROB_W-1:0] <= ONE_PROB))
    else $error("result probability above one");

endmodule
